FILE: rtl/core/ormw_pkg.sv
// Shared types, widths and codes for the overwrite ring with window mean.
`timescale 1ns / 1ps
`default_nettype none

package ormw_pkg;

  // Field widths fixed by the port definition
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 7;
  localparam int HEAD_W   = 6;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = SAMPLE_W + LEN_W;

  // Default ring storage depth and ring_length after reset
  localparam int                DEPTH_DEF    = 64;
  localparam logic [LEN_W-1:0]  RING_LEN_RST = 7'd64;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // Function codes on the input channel
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MEAN  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_GET,
    OP_MEAN,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_SUM,
    S_DIV,
    S_FIN
  } exec_state_t;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]           window_count;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/ormw_if.sv
// Valid/ready channel interfaces: input items, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface ormw_in_if import ormw_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [SAMPLE_W-1:0] sample;
  logic [LEN_W-1:0]           window_count;

  modport source (output valid, func, sample, window_count, input ready);
  modport sink   (input valid, func, sample, window_count, output ready);
endinterface

interface ormw_out_if import ormw_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] read_value;
  logic [SAMPLE_W-1:0]        mean_magnitude;
  logic [STATUS_W-1:0]        status;
  logic [HEAD_W-1:0]          head_position;
  logic [LEN_W-1:0]           fill_count;
  logic                       is_full;
  logic                       is_empty;

  modport source (output valid, read_value, mean_magnitude, status, head_position,
                  fill_count, is_full, is_empty, input ready);
  modport sink   (input valid, read_value, mean_magnitude, status, head_position,
                  fill_count, is_full, is_empty, output ready);
endinterface

interface ormw_cfg_if import ormw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] ring_length;

  modport source (output valid, ring_length, input ready);
  modport sink   (input valid, ring_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ormw_front.sv
// Front end: decodes input items and holds them in a short command queue.
`timescale 1ns / 1ps
`default_nettype none

module ormw_front import ormw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ormw_in_if.sink   in_ch,
  input  logic      q_pop,
  output q_head_t   q_head
);

  cmd_t                  q_mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_PTR_W:0]   cnt_r;
  logic                  push;
  cmd_t                  cmd_in;

  function automatic op_t decode_func(input logic [FUNC_W-1:0] f);
    op_t op;
    unique case (f)
      FUNC_PUT:   op = OP_PUT;
      FUNC_GET:   op = OP_GET;
      FUNC_MEAN:  op = OP_MEAN;
      FUNC_CLEAR: op = OP_CLEAR;
    endcase
    return op;
  endfunction

  assign in_ch.ready = (cnt_r != (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    cmd_in.op           = decode_func(in_ch.func);
    cmd_in.sample       = in_ch.sample;
    cmd_in.window_count = in_ch.window_count;
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.cmd   = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_PTR_W'(1);
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + (CMDQ_PTR_W+1)'(1);
      end else if (q_pop && !push) begin
        cnt_r <= cnt_r - (CMDQ_PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ormw_div.sv
// Restoring radix-2 divider: window magnitude sum by window count, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module ormw_div import ormw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r;
  logic [LEN_W-1:0] rem_r;
  logic [LEN_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             q_bit;
  logic [LEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    diff    = trial - {1'b0, dvs_r};
    q_bit   = (trial >= {1'b0, dvs_r});
    rem_nxt = q_bit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ormw_back.sv
// Back end: ring storage, pointers, window walk and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module ormw_back import ormw_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   q_head,
  output logic      q_pop,
  ormw_cfg_if.sink  cfg_ch,
  ormw_out_if.source out_ch,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  // ring storage
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic                mem_we;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_vld_r;

  // ring state
  exec_state_t      state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic             full_r, full_nxt;
  logic [LEN_W-1:0] ring_len_r;

  // window walk
  logic [PTR_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // result
  logic                       res_load;
  logic signed [SAMPLE_W-1:0] res_read;
  logic [SAMPLE_W-1:0]        res_mean;
  logic [STATUS_W-1:0]        res_status;
  logic [LEN_W-1:0]           res_fill;
  logic                       out_valid_r;

  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    fill_now;
  logic                empty_now;
  logic                win_bad;
  logic                out_free;
  logic                cfg_wr;
  logic [SAMPLE_W-1:0] mag;
  cmd_t                cmd;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] idx,
                                            input logic [LEN_W-1:0] l);
    logic [CMP_W-1:0] nx;
    nx = CMP_W'(idx) + CMP_W'(1);
    return (nx >= CMP_W'(l)) ? '0 : PTR_W'(nx);
  endfunction

  function automatic logic [PTR_W-1:0] step_back(input logic [PTR_W-1:0] p,
                                                 input logic [LEN_W-1:0] l);
    return (p == '0) ? PTR_W'(l - LEN_W'(1)) : p - PTR_W'(1);
  endfunction

  function automatic logic [LEN_W-1:0] fill_of(input logic [PTR_W-1:0] h,
                                               input logic [PTR_W-1:0] t,
                                               input logic             f,
                                               input logic [LEN_W-1:0] l);
    logic [CMP_W-1:0] d;
    if (h >= t) begin
      d = CMP_W'(h) - CMP_W'(t);
    end else begin
      d = CMP_W'(l) + CMP_W'(h) - CMP_W'(t);
    end
    return f ? l : LEN_W'(d);
  endfunction

  // ring_length of zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    priority if (ring_len_r == '0) begin
      len = LEN_W'(1);
    end else if (CMP_W'(ring_len_r) > CMP_W'(DEPTH)) begin
      len = LEN_W'(DEPTH);
    end else begin
      len = ring_len_r;
    end
  end

  assign cmd       = q_head.cmd;
  assign fill_now  = fill_of(head_r, tail_r, full_r, len);
  assign empty_now = !full_r && (head_r == tail_r);
  assign win_bad   = (cmd.window_count == '0) || (cmd.window_count > fill_now);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign cfg_wr    = cfg_ch.valid && cfg_ch.ready;
  assign mag       = rd_data_r[SAMPLE_W-1] ? (-rd_data_r) : rd_data_r;

  assign cfg_ch.ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          if (cmd.op == OP_GET && !empty_now) begin
            state_nxt = S_GET;
          end else if (cmd.op == OP_MEAN && !win_bad) begin
            state_nxt = S_SUM;
          end
        end
      end
      S_GET: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SUM: begin
        if (left_r == '0 && !rd_vld_r) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = tail_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    full_nxt   = full_r;
    pos_nxt    = pos_r;
    left_nxt   = left_r;
    n_nxt      = n_r;
    sum_nxt    = sum_r;
    res_load   = 1'b0;
    res_read   = '0;
    res_mean   = '0;
    res_status = STAT_OK;
    div_req.start    = 1'b0;
    div_req.dividend = sum_r;
    div_req.divisor  = n_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          unique case (cmd.op)
            OP_PUT: begin
              if (out_free) begin
                q_pop    = 1'b1;
                mem_we   = 1'b1;
                res_load = 1'b1;
                head_nxt = bump(head_r, len);
                tail_nxt = full_r ? bump(tail_r, len) : tail_r;
                full_nxt = (head_nxt == tail_nxt);
              end
            end
            OP_GET: begin
              if (empty_now) begin
                if (out_free) begin
                  q_pop      = 1'b1;
                  res_load   = 1'b1;
                  res_status = STAT_EMPTY;
                end
              end else begin
                q_pop   = 1'b1;
                rd_en   = 1'b1;
                rd_addr = tail_r;
              end
            end
            OP_MEAN: begin
              if (win_bad) begin
                if (out_free) begin
                  q_pop      = 1'b1;
                  res_load   = 1'b1;
                  res_status = STAT_BAD_WINDOW;
                end
              end else begin
                q_pop    = 1'b1;
                sum_nxt  = '0;
                left_nxt = cmd.window_count;
                n_nxt    = cmd.window_count;
                pos_nxt  = step_back(head_r, len);
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                q_pop    = 1'b1;
                res_load = 1'b1;
                head_nxt = '0;
                tail_nxt = '0;
                full_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      S_GET: begin
        if (out_free) begin
          res_load = 1'b1;
          res_read = rd_data_r;
          full_nxt = 1'b0;
          tail_nxt = bump(tail_r, len);
        end
      end
      S_SUM: begin
        // one read issued per cycle, newest first; the registered data lands in the next cycle
        if (left_r != '0) begin
          rd_en    = 1'b1;
          rd_addr  = pos_r;
          pos_nxt  = step_back(pos_r, len);
          left_nxt = left_r - LEN_W'(1);
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SUM_W'(mag);
        end
        if (left_r == '0 && !rd_vld_r) begin
          div_req.start = 1'b1;
        end
      end
      S_DIV: begin
      end
      S_FIN: begin
        if (out_free) begin
          res_load = 1'b1;
          res_mean = SAMPLE_W'(div_rsp.quotient);
        end
      end
      default: begin
      end
    endcase
  end

  assign res_fill = fill_of(head_nxt, tail_nxt, full_nxt, len);

  // storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head_r] <= cmd.sample;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    left_r <= left_nxt;
    n_r    <= n_nxt;
    sum_r  <= sum_nxt;
    if (res_load) begin
      out_ch.read_value     <= res_read;
      out_ch.mean_magnitude <= res_mean;
      out_ch.status         <= res_status;
      out_ch.head_position  <= HEAD_W'(head_nxt);
      out_ch.fill_count     <= res_fill;
      out_ch.is_full        <= (res_fill == len);
      out_ch.is_empty       <= (res_fill == '0);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      full_r      <= 1'b0;
      ring_len_r  <= RING_LEN_RST;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en && (state_r == S_SUM);
      priority if (cfg_wr) begin
        ring_len_r <= cfg_ch.ring_length;
        head_r     <= '0;
        tail_r     <= '0;
        full_r     <= 1'b0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        full_r <= full_nxt;
      end
      priority if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/overwrite_ring_with_window_mean_top.sv
// Top level of the overwrite ring with window mean: front, back and divider.
`timescale 1ns / 1ps
`default_nettype none

// Ring FIFO of signed Q8.8 samples with an overwrite-on-full put, a get of
// the oldest entry, a truncated mean of the magnitudes of the n newest
// entries, and a pointer clear. Each input transfer yields exactly one result
// transfer that carries the head index, fill count and full/empty flags after
// the operation. Items enter a two-deep command queue, so the input side
// keeps taking transfers, until the queue is full, while a result waits at
// the output register. At the back end, a get does a registered memory
// read at the tail, and a window mean of n entries reads one ring entry
// per cycle through the single memory read port, then a radix-2 divider
// forms the quotient. The ring storage is not cleared; entries are only
// ever read after being written. A write on the cfg channel sets
// ring_length and clears the pointers; it is taken in any cycle, and is
// expected only while idle.

module overwrite_ring_with_window_mean_top import ormw_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ormw_in_if.sink    in_ch,
  ormw_out_if.source out_ch,
  ormw_cfg_if.sink   cfg_ch
);

  q_head_t  q_head;   // oldest queued command
  logic     q_pop;    // back takes it
  div_req_t div_req;
  div_rsp_t div_rsp;

  // decode and queue
  ormw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  // storage, pointers, window walk, result register
  ormw_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // serial divider for the window mean
  ormw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back never pops an empty queue
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("pop from empty command queue");

  // ring length is at least one, so full and empty never coincide
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.is_full && out_ch.is_empty))
    else $error("result reports full and empty together");

  // empty flag tracks the fill count
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.is_empty == (out_ch.fill_count == '0)))
    else $error("empty flag disagrees with fill count");

  // rejected ops return no data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != STAT_OK) |->
      (out_ch.read_value == '0 && out_ch.mean_magnitude == '0))
    else $error("error result carries data");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for the overwrite ring with window mean: stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_top;
  import ormw_pkg::*;

  localparam int RING_SLOTS    = DEPTH_DEF;
  // Idle cycles after the last result, before a length write or the end
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any transfer before the run is called hung. The slowest
  // item is a full-ring mean; the receiver stalls up to 82% of the time.
  localparam int STALL_LIMIT   = 5000;

  typedef struct {
    logic [FUNC_W-1:0]          func;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]           window_count;
  } ring_op_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] read_value;
    logic [SAMPLE_W-1:0]        mean_magnitude;
    logic [STATUS_W-1:0]        status;
    logic [HEAD_W-1:0]          head_position;
    logic [LEN_W-1:0]           fill_count;
    logic                       is_full;
    logic                       is_empty;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ormw_in_if  in_bus ();
  ormw_out_if out_bus ();
  ormw_cfg_if cfg_bus ();

  overwrite_ring_with_window_mean_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Items waiting to be driven; the head is the one on the bus while valid is up
  ring_op_t     pending_ops[$];
  // Results predicted at input acceptance, oldest first
  ring_result_t predicted_results[$];

  // Shadow copy of the ring
  logic signed [SAMPLE_W-1:0] shadow_mem [RING_SLOTS];
  int unsigned                shadow_head;
  int unsigned                shadow_tail;
  bit                         shadow_full;
  logic [LEN_W-1:0]           shadow_len;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches   = 0;
  int stall_cycles = 0;
  int n_items      = 0;
  int n_means      = 0;
  int n_empty_gets = 0;
  int n_len_writes = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Length 0 behaves as 1, anything above the storage depth as the depth
  function automatic int unsigned clamp_len(logic [LEN_W-1:0] v);
    if (v < 1) return 1;
    if (v > RING_SLOTS) return RING_SLOTS;
    return v;
  endfunction

  function automatic int unsigned shadow_fill();
    int unsigned len;
    len = clamp_len(shadow_len);
    if (shadow_full) return len;
    if (shadow_head >= shadow_tail) return shadow_head - shadow_tail;
    return len + shadow_head - shadow_tail;
  endfunction

  function automatic int unsigned next_slot(int unsigned idx);
    return (idx + 1 >= clamp_len(shadow_len)) ? 0 : idx + 1;
  endfunction

  function automatic void clear_shadow_ptrs();
    shadow_head = 0;
    shadow_tail = 0;
    shadow_full = 1'b0;
  endfunction

  // Applies one operation to the shadow ring and returns the result it yields
  function automatic ring_result_t apply_ring_op(ring_op_t op);
    ring_result_t r;
    int unsigned  len;
    int unsigned  pos;
    int unsigned  sum;
    int unsigned  cnt;
    int           mag;
    int           k;
    len              = clamp_len(shadow_len);
    r.read_value     = '0;
    r.mean_magnitude = '0;
    r.status         = STAT_OK;
    case (op.func)
      FUNC_PUT: begin
        // full ring: the oldest entry goes, tail moves with head
        shadow_mem[shadow_head] = op.sample;
        if (shadow_full) shadow_tail = next_slot(shadow_tail);
        shadow_head = next_slot(shadow_head);
        shadow_full = (shadow_head == shadow_tail);
      end
      FUNC_GET: begin
        if (!shadow_full && shadow_head == shadow_tail) begin
          r.status = STAT_EMPTY;
        end else begin
          r.read_value = shadow_mem[shadow_tail];
          shadow_full  = 1'b0;
          shadow_tail  = next_slot(shadow_tail);
        end
      end
      FUNC_MEAN: begin
        if (op.window_count == 0 || op.window_count > shadow_fill()) begin
          r.status = STAT_BAD_WINDOW;
        end else begin
          // walk back from the head over the newest entries
          sum = 0;
          pos = shadow_head;
          for (k = 0; k < op.window_count; k++) begin
            pos = (pos == 0) ? len - 1 : pos - 1;
            mag = shadow_mem[pos];
            if (mag < 0) mag = -mag;
            sum += mag;
          end
          r.mean_magnitude = SAMPLE_W'(sum / op.window_count);
        end
      end
      default: begin
        clear_shadow_ptrs();
      end
    endcase
    cnt             = shadow_fill();
    r.head_position = HEAD_W'(shadow_head);
    r.fill_count    = LEN_W'(cnt);
    r.is_full       = (cnt == len);
    r.is_empty      = (cnt == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: predicts each accepted transfer, then presents the next item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : op_driver
    ring_result_t r;
    bit           took;
    took = 1'b0;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      clear_shadow_ptrs();
      shadow_len = RING_LEN_RST;
    end else begin
      // length write: new length, pointers cleared
      if (cfg_bus.valid && cfg_bus.ready) begin
        shadow_len = cfg_bus.ring_length;
        clear_shadow_ptrs();
        n_len_writes++;
      end
      if (in_bus.valid && in_bus.ready) begin
        r = apply_ring_op(pending_ops[0]);
        predicted_results.push_back(r);
        n_items++;
        if (pending_ops[0].func == FUNC_MEAN && r.status == STAT_OK) n_means++;
        if (r.status == STAT_EMPTY) n_empty_gets++;
        void'(pending_ops.pop_front());
        took = 1'b1;
      end
      // valid holds until the transfer; a new item may follow back to back
      if (!in_bus.valid || took) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_bus.valid        <= 1'b1;
          in_bus.func         <= pending_ops[0].func;
          in_bus.sample       <= pending_ops[0].sample;
          in_bus.window_count <= pending_ops[0].window_count;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, field-by-field compare
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    ring_result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result transfer with no prediction waiting");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("read_value", want.read_value, out_bus.read_value);
          check_field("mean_magnitude", want.mean_magnitude, out_bus.mean_magnitude);
          check_field("status", want.status, out_bus.status);
          check_field("head_position", want.head_position, out_bus.head_position);
          check_field("fill_count", want.fill_count, out_bus.fill_count);
          check_field("is_full", want.is_full, out_bus.is_full);
          check_field("is_empty", want.is_empty, out_bus.is_empty);
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any transfer on any channel resets the count
  always @(posedge clk) begin : hang_watch
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_op(input logic [FUNC_W-1:0] func, input logic [SAMPLE_W-1:0] smp,
                          input logic [LEN_W-1:0] wc);
    ring_op_t op;
    op.func         = func;
    op.sample       = smp;
    op.window_count = wc;
    pending_ops.push_back(op);
  endtask

  // Wait for every item to be taken and every result to come back
  task automatic settle();
    while (pending_ops.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle
  task automatic write_len(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.ring_length <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Mostly legal traffic against a tracked fill level, with some bad windows
  task automatic random_phase(input logic [LEN_W-1:0] len_value, input int count);
    int unsigned         len;
    int unsigned         fill;
    int unsigned         pick;
    int                  k;
    logic [LEN_W-1:0]    wc;
    logic [SAMPLE_W-1:0] smp;
    write_len(len_value);
    len  = clamp_len(len_value);
    fill = 0;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       smp = 16'h7FFF;
          1:       smp = 16'h8000;
          2:       smp = 16'h0000;
          default: smp = 16'hFFFF;
        endcase
      end else begin
        smp = SAMPLE_W'($urandom_range(0, 65535));
      end
      wc   = LEN_W'($urandom_range(0, 127));
      pick = $urandom_range(99);
      if (pick < 45) begin
        queue_op(FUNC_PUT, smp, wc);
        if (fill < len) fill++;
      end else if (pick < 67) begin
        queue_op(FUNC_GET, smp, wc);
        if (fill > 0) fill--;
      end else if (pick < 95) begin
        if (fill > 0 && $urandom_range(99) < 85) begin
          // whole-window averages now and then
          wc = ($urandom_range(9) == 0) ? LEN_W'(fill) : LEN_W'($urandom_range(1, fill));
        end
        queue_op(FUNC_MEAN, smp, wc);
      end else begin
        queue_op(FUNC_CLEAR, smp, wc);
        fill = 0;
      end
    end
    settle();
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0] lens [12];
    int               i;
    lens = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd5, 7'd17, 7'd63, 7'd0, 7'd100, 7'd8, 7'd33, 7'd64};

    // every input known from time zero
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.func          = FUNC_PUT;
    in_bus.sample        = '0;
    in_bus.window_count  = '0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.ring_length  = '0;
    send_idle_pct        = 21;
    recv_idle_pct        = 82;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset length: empty ring, bad windows, sample extremes
    queue_op(FUNC_GET,  16'h0000, 7'd0);     // get on empty
    queue_op(FUNC_MEAN, 16'h0000, 7'd0);     // zero window
    queue_op(FUNC_MEAN, 16'h0000, 7'd1);     // window above fill
    queue_op(FUNC_PUT,  16'h7FFF, 7'd0);
    queue_op(FUNC_PUT,  16'h8000, 7'd0);
    queue_op(FUNC_PUT,  16'h0000, 7'd0);
    queue_op(FUNC_PUT,  16'hFFFF, 7'd127);
    queue_op(FUNC_MEAN, 16'h0000, 7'd4);
    queue_op(FUNC_MEAN, 16'h0000, 7'd127);   // all ones, far above fill
    queue_op(FUNC_GET,  16'h0000, 7'd0);
    queue_op(FUNC_GET,  16'h0000, 7'd0);
    queue_op(FUNC_MEAN, 16'h0000, 7'd1);     // magnitude of the newest, -1
    queue_op(FUNC_CLEAR, 16'h0000, 7'd0);
    queue_op(FUNC_GET,  16'h0000, 7'd0);
    settle();

    // Short ring: overwrite on full, whole ring averaged, drain to empty
    write_len(7'd3);
    queue_op(FUNC_PUT,  16'h0100, 7'd0);
    queue_op(FUNC_PUT,  16'hFF00, 7'd0);
    queue_op(FUNC_PUT,  16'h8000, 7'd0);
    queue_op(FUNC_PUT,  16'h7FFF, 7'd0);
    queue_op(FUNC_MEAN, 16'h0000, 7'd3);
    queue_op(FUNC_MEAN, 16'h0000, 7'd4);
    queue_op(FUNC_GET,  16'h0000, 7'd0);
    queue_op(FUNC_GET,  16'h0000, 7'd0);
    queue_op(FUNC_GET,  16'h0000, 7'd0);
    queue_op(FUNC_GET,  16'h0000, 7'd0);
    settle();

    // Length zero behaves as a single slot
    write_len(7'd0);
    queue_op(FUNC_PUT,  16'h1234, 7'd0);
    queue_op(FUNC_PUT,  16'h8001, 7'd0);
    queue_op(FUNC_MEAN, 16'h0000, 7'd1);
    queue_op(FUNC_GET,  16'h0000, 7'd0);
    settle();

    // Random phases: slow receiver first, then slow sender, then full speed
    for (i = 0; i < 12; i++) begin
      if (i == 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 21;
      end else if (i == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase(lens[i], 130);
    end

    repeat (20) @(posedge clk);
    $display("ran %0d operations across %0d ring length settings", n_items, n_len_writes);
    $display("  incl. %0d valid window means and %0d gets on an empty ring",
             n_means, n_empty_gets);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
